>>> src/srwf_pkg.sv
// shared types, constants and exp tables for the row softmax with floor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package srwf_pkg;

	localparam int MAX_ROW_DEF = 64;
	localparam int CNT_W       = 7;
	localparam int ADDR_W      = 6;
	localparam int SUM_W       = 23;
	localparam int PROB_W      = 17;
	localparam logic signed [31:0] FLOOR_RESET = -32'sd65536000;

	// row descriptor handed from the front to the back
	typedef struct packed {
		logic signed [31:0] mx;
		logic signed [31:0] floor_v;
		logic [CNT_W-1:0]   cnt;
		logic               cut;
	} srwf_desc_t;

	// write into the row store
	typedef struct packed {
		logic                en;
		logic [ADDR_W-1:0]   addr;
		logic signed [31:0]  data;
	} srwf_wr_t;

	typedef struct packed {
		logic busy;
	} srwf_stat_t;

	// exp(-n), n = 0..11
	function automatic logic [16:0] expi(input logic [3:0] n);
		logic [16:0] r;
		case (n)
			4'd0:    r = 17'd65536;
			4'd1:    r = 17'd24109;
			4'd2:    r = 17'd8869;
			4'd3:    r = 17'd3263;
			4'd4:    r = 17'd1200;
			4'd5:    r = 17'd442;
			4'd6:    r = 17'd162;
			4'd7:    r = 17'd60;
			4'd8:    r = 17'd22;
			4'd9:    r = 17'd8;
			4'd10:   r = 17'd3;
			4'd11:   r = 17'd1;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

	// exp(-k/16)
	function automatic logic [16:0] exph(input logic [3:0] k);
		logic [16:0] r;
		case (k)
			4'd0:    r = 17'd65536;
			4'd1:    r = 17'd61565;
			4'd2:    r = 17'd57835;
			4'd3:    r = 17'd54331;
			4'd4:    r = 17'd51039;
			4'd5:    r = 17'd47947;
			4'd6:    r = 17'd45042;
			4'd7:    r = 17'd42313;
			4'd8:    r = 17'd39750;
			4'd9:    r = 17'd37341;
			4'd10:   r = 17'd35079;
			4'd11:   r = 17'd32954;
			4'd12:   r = 17'd30957;
			4'd13:   r = 17'd29081;
			4'd14:   r = 17'd27319;
			default: r = 17'd25664;
		endcase
		return r;
	endfunction

	// exp(-k/256)
	function automatic logic [16:0] expl(input logic [3:0] k);
		logic [16:0] r;
		case (k)
			4'd0:    r = 17'd65536;
			4'd1:    r = 17'd65280;
			4'd2:    r = 17'd65026;
			4'd3:    r = 17'd64772;
			4'd4:    r = 17'd64520;
			4'd5:    r = 17'd64268;
			4'd6:    r = 17'd64018;
			4'd7:    r = 17'd63768;
			4'd8:    r = 17'd63520;
			4'd9:    r = 17'd63272;
			4'd10:   r = 17'd63025;
			4'd11:   r = 17'd62780;
			4'd12:   r = 17'd62535;
			4'd13:   r = 17'd62291;
			4'd14:   r = 17'd62048;
			default: r = 17'd61806;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/srwf_front.sv
// front end: takes scores, writes the row store, tracks the running maximum
// uses srwf_pkg; pushes one descriptor per row into the queue
`timescale 1ns / 1ps
`default_nettype none
module srwf_front import srwf_pkg::*; #(
	parameter int MAX_ROW = MAX_ROW_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic signed [31:0] floor_v,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] in_score,
	input  wire logic               in_end,
	input  wire logic               q_empty,
	input  wire srwf_stat_t         back_stat,
	output srwf_wr_t                wr,
	output logic                    push,
	output srwf_desc_t              push_desc
);

	logic [CNT_W-1:0]   count_q;
	logic signed [31:0] rm_q;
	logic               cut_q;
	logic               acc, stored;
	logic signed [31:0] rm_base, rm_new;
	logic [CNT_W-1:0]   cnt_new;

	// the store is shared with the back end, so hold off while a row is in flight
	assign in_ready = q_empty && !back_stat.busy;
	assign acc      = in_valid && in_ready;
	assign stored   = count_q < CNT_W'(MAX_ROW);
	assign rm_base  = (count_q == '0) ? floor_v : rm_q;
	assign rm_new   = (stored && in_score > rm_base) ? in_score : rm_base;
	assign cnt_new  = stored ? count_q + CNT_W'(1) : count_q;

	always_comb begin
		wr.en   = acc && stored;
		wr.addr = count_q[ADDR_W-1:0];
		wr.data = in_score;
		push    = acc && in_end;
		push_desc.mx      = (rm_new > floor_v) ? rm_new : floor_v;
		push_desc.floor_v = floor_v;
		push_desc.cnt     = cnt_new;
		push_desc.cut     = cut_q || !stored;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rm_q    <= FLOOR_RESET;
			cut_q   <= 1'b0;
		end else if (acc) begin
			if (in_end) begin
				count_q <= '0;
				cut_q   <= 1'b0;
				rm_q    <= floor_v;
			end else begin
				count_q <= cnt_new;
				cut_q   <= cut_q || !stored;
				rm_q    <= rm_new;
			end
		end
	end

endmodule
`default_nettype wire

>>> src/srwf_queue.sv
// two-entry descriptor queue between front and back
// uses srwf_pkg
`timescale 1ns / 1ps
`default_nettype none
module srwf_queue import srwf_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire srwf_desc_t push_desc,
	input  wire logic       pop,
	output srwf_desc_t      head,
	output logic            empty
);

	srwf_desc_t ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] fill_q;

	assign head  = ent_q[rp_q];
	assign empty = (fill_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push && fill_q != 2'd2) ent_q[wp_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push && fill_q != 2'd2) wp_q <= ~wp_q;
			if (pop && !empty) rp_q <= ~rp_q;
			fill_q <= fill_q + 2'((push && fill_q != 2'd2) ? 1 : 0)
				- 2'((pop && !empty) ? 1 : 0);
		end
	end

endmodule
`default_nettype wire

>>> src/srwf_back.sv
// back end: row store, shared exp unit, sum pass, normalise pass with serial divider
// uses srwf_pkg; reads descriptors from srwf_queue
`timescale 1ns / 1ps
`default_nettype none
module srwf_back import srwf_pkg::*; #(
	parameter int MAX_ROW = MAX_ROW_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire srwf_wr_t    wr,
	input  wire logic        q_empty,
	input  wire srwf_desc_t  head,
	output logic             pop,
	output srwf_stat_t       stat,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [PROB_W-1:0] out_prob,
	output logic             out_last,
	output logic             out_ovf
);

	localparam int AW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;

	typedef enum logic [3:0] {
		IDLE, WAIT, LOAD, E0, E1, E2, DIV, OUT
	} state_t;

	logic signed [31:0] mem [MAX_ROW];
	logic signed [31:0] rdata_q;

	state_t             state_q;
	srwf_desc_t         d_q;
	logic [CNT_W-1:0]   idx_q;
	logic               norm_q;
	logic               fterm_q;
	logic [32:0]        x_q;
	logic [16:0]        v_q;
	logic               big_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W-1:0]   rem_q;
	logic [16:0]        nlo_q;
	logic [16:0]        quo_q;
	logic [4:0]         step_q;

	logic [33:0]        prod0, prod1, prod2;
	logic [16:0]        e_val;
	logic [33:0]        numer;
	logic [SUM_W:0]     rem2;
	logic               last_el;

	always_ff @(posedge clk) begin
		if (wr.en) mem[wr.addr[AW-1:0]] <= wr.data;
		rdata_q <= mem[idx_q[AW-1:0]];
	end

	assign prod0 = 34'(expi(x_q[19:16])) * 34'(exph(x_q[15:12]));
	assign prod1 = 34'(v_q) * 34'(expl(x_q[11:8]));
	assign prod2 = 34'(v_q) * 34'(17'd65536 - 17'(x_q[7:0]));
	assign e_val = big_q ? 17'd0 : prod2[32:16] + 17'(prod2[15]);
	assign numer = {e_val, 16'd0} + 34'(sum_q[SUM_W-1:1]);
	assign rem2  = {rem_q, nlo_q[16]};
	assign last_el = (idx_q + CNT_W'(1) == d_q.cnt);

	assign pop       = (state_q == IDLE) && !q_empty;
	assign stat.busy = (state_q != IDLE) || !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			idx_q     <= '0;
			norm_q    <= 1'b0;
			fterm_q   <= 1'b0;
			sum_q     <= '0;
			step_q    <= '0;
			out_valid <= 1'b0;
			out_prob  <= '0;
			out_last  <= 1'b0;
			out_ovf   <= 1'b0;
			d_q       <= '0;
			x_q       <= '0;
			v_q       <= '0;
			big_q     <= 1'b0;
			rem_q     <= '0;
			nlo_q     <= '0;
			quo_q     <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (!q_empty) begin
						// extra floor term goes first
						d_q     <= head;
						x_q     <= 33'(head.mx) - 33'(head.floor_v);
						idx_q   <= '0;
						norm_q  <= 1'b0;
						fterm_q <= 1'b1;
						sum_q   <= '0;
						state_q <= E0;
					end
				end
				WAIT: state_q <= LOAD;
				LOAD: begin
					x_q     <= 33'(d_q.mx) - 33'(rdata_q);
					state_q <= E0;
				end
				E0: begin
					big_q   <= x_q[32:16] >= 17'd12;
					v_q     <= prod0[32:16] + 17'(prod0[15]);
					state_q <= E1;
				end
				E1: begin
					v_q     <= prod1[32:16] + 17'(prod1[15]);
					state_q <= E2;
				end
				E2: begin
					if (!norm_q) begin
						sum_q <= sum_q + SUM_W'(e_val);
						// the floor term leaves idx_q on the first stored score
						if (fterm_q) begin
							fterm_q <= 1'b0;
						end else if (last_el) begin
							norm_q <= 1'b1;
							idx_q  <= '0;
						end else begin
							idx_q <= idx_q + CNT_W'(1);
						end
						state_q <= WAIT;
					end else begin
						rem_q   <= SUM_W'(numer[32:17]);
						nlo_q   <= numer[16:0];
						quo_q   <= '0;
						step_q  <= 5'd17;
						state_q <= DIV;
					end
				end
				DIV: begin
					if (rem2 >= {1'b0, sum_q}) begin
						rem_q <= SUM_W'(rem2 - {1'b0, sum_q});
						quo_q <= {quo_q[15:0], 1'b1};
					end else begin
						rem_q <= rem2[SUM_W-1:0];
						quo_q <= {quo_q[15:0], 1'b0};
					end
					nlo_q  <= {nlo_q[15:0], 1'b0};
					step_q <= step_q - 5'd1;
					if (step_q == 5'd1) begin
						state_q <= OUT;
					end
				end
				OUT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						out_prob  <= (sum_q == '0) ? '0 : quo_q;
						out_last  <= last_el;
						out_ovf   <= d_q.cut;
					end else if (out_ready) begin
						out_valid <= 1'b0;
						if (last_el) begin
							state_q <= IDLE;
						end else begin
							idx_q   <= idx_q + CNT_W'(1);
							state_q <= WAIT;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> src/softmax_row_with_floor_core.sv
// top level of the row softmax with floor: front, descriptor queue, back end
// uses srwf_pkg, srwf_front, srwf_queue, srwf_back
// after the last score of a row, a sum pass runs the floor term and each stored score
// through the three-step exp unit; then each probability, the first and each later one
// once the previous is taken, comes from the exp unit and the 17-step serial divider
// throughput: one score a cycle on input, but input stalls while a row is processed
// reset: asynchronous, active low; clears counters, queue and control, floor to -1000.0
`timescale 1ns / 1ps
`default_nettype none
module softmax_row_with_floor_core import srwf_pkg::*; #(
	parameter int MAX_ROW = MAX_ROW_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,      // floor_value
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [31:0] score
	input  wire logic        s_axis_tlast,  // row_end
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // [16:0] probability, rest zero
	output logic             m_axis_tlast,  // last_out
	output logic             m_axis_tuser   // overflow
);

	logic signed [31:0] floor_q;
	srwf_wr_t           wr;
	srwf_desc_t         push_desc, head;
	srwf_stat_t         back_stat;
	logic               push, pop, q_empty;
	logic [PROB_W-1:0]  prob;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= FLOOR_RESET;
		end else if (cfg_valid) begin
			floor_q <= cfg_data;
		end
	end

	srwf_front #(.MAX_ROW(MAX_ROW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.floor_v   (floor_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_score  (s_axis_tdata),
		.in_end    (s_axis_tlast),
		.q_empty   (q_empty),
		.back_stat (back_stat),
		.wr        (wr),
		.push      (push),
		.push_desc (push_desc)
	);

	srwf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty)
	);

	srwf_back #(.MAX_ROW(MAX_ROW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.stat      (back_stat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_prob  (prob),
		.out_last  (m_axis_tlast),
		.out_ovf   (m_axis_tuser)
	);

	assign m_axis_tdata = {7'd0, prob};

endmodule
`default_nettype wire
